[src/efsa_pkg.sv]
// Shared types and constants for the earliest-free server assigner.
// Used by efsa_csr, efsa_core and earliest_free_server_assigner.
package efsa_pkg;

   // server file depth and derived index width
   localparam int NUM_SERVERS = 16;
   localparam int SRV_IDX_W   = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;

   // fixed field widths
   localparam int CMD_W    = 1;
   localparam int INDEX_W  = 4;
   localparam int RATE_W   = 8;
   localparam int COUNT_W  = 8;
   localparam int TIME_W   = 32;
   localparam int PROD_W   = RATE_W + COUNT_W;
   localparam int SCOUNT_W = 5;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_SERVER_COUNT = 1'b0;   // word index, paddr[2]

   // request commands
   localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
   localparam logic [CMD_W-1:0] CMD_JOB  = 1'b1;

   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   typedef struct packed {
      logic [SCOUNT_W-1:0] server_count;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_RATE,
      ST_MULT,
      ST_WRITE
   } state_type;

endpackage

[src/efsa_csr.sv]
// APB-style configuration register file for the server assigner.
// Holds server_count; depends on efsa_pkg.
module efsa_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [efsa_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [efsa_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [efsa_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output efsa_pkg::cfg_type                 cfg
);

   logic [efsa_pkg::SCOUNT_W-1:0] server_count_ff;
   logic [efsa_pkg::SCOUNT_W-1:0] server_count_in;
   logic                          wr_en;
   logic                          sel_count;

   // word decode: paddr[2] selects the word; the low two address bits are ignored
   assign sel_count = (csr_paddr[2] == efsa_pkg::REG_SERVER_COUNT);
   assign wr_en     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      server_count_in = server_count_ff;
      if (wr_en && sel_count) begin
         server_count_in = csr_pwdata[efsa_pkg::SCOUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         server_count_ff <= efsa_pkg::SCOUNT_W'(1);
      end else begin
         server_count_ff <= server_count_in;
      end
   end

   // read-back
   always_comb begin
      csr_prdata = '0;
      if (sel_count) begin
         csr_prdata = efsa_pkg::CSR_DATA_W'(server_count_ff);
      end
   end

   assign csr_pready       = 1'b1;
   assign cfg.server_count = server_count_ff;

endmodule

[src/efsa_core.sv]
// Sequencer and datapath of the server assigner: rate and free-time
// memories, serial scan compare, multiply and saturating add. Uses efsa_pkg.
module efsa_core (
   input  logic                             clock,
   input  logic                             reset,
   input  efsa_pkg::cfg_type                cfg,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [efsa_pkg::CMD_W-1:0]       req_cmd,
   input  logic [efsa_pkg::INDEX_W-1:0]     req_server_index,
   input  logic [efsa_pkg::RATE_W-1:0]      req_rate_value,
   input  logic [efsa_pkg::COUNT_W-1:0]     req_item_count,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [efsa_pkg::INDEX_W-1:0]     rsp_chosen_server,
   output logic [efsa_pkg::TIME_W-1:0]      rsp_finish_time,
   output logic [efsa_pkg::TIME_W-1:0]      rsp_makespan
);

   localparam int IW = efsa_pkg::SRV_IDX_W;
   localparam int TW = efsa_pkg::TIME_W;

   efsa_pkg::state_type state_ff, state_in;

   // memories
   logic [efsa_pkg::RATE_W-1:0] rate_mem [efsa_pkg::NUM_SERVERS];
   logic [TW-1:0]               ft_mem   [efsa_pkg::NUM_SERVERS];
   logic [efsa_pkg::RATE_W-1:0] rate_q_ff;
   logic [TW-1:0]               ft_q_ff;
   logic [efsa_pkg::NUM_SERVERS-1:0] ft_vld_ff, ft_vld_in;

   // sequencer registers
   logic [IW-1:0]                scan_idx_ff, scan_idx_in;
   logic [IW-1:0]                last_ff, last_in;
   logic [efsa_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                         rd_vld_ff, rd_vld_in;
   logic [IW-1:0]                rd_tag_ff, rd_tag_in;
   logic [IW-1:0]                best_idx_ff, best_idx_in;
   logic [TW-1:0]                best_val_ff, best_val_in;
   logic [efsa_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [TW-1:0]                max_ff, max_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [efsa_pkg::INDEX_W-1:0] rsp_srv_ff, rsp_srv_in;
   logic [TW-1:0]                rsp_fin_ff, rsp_fin_in;
   logic [TW-1:0]                rsp_max_ff, rsp_max_in;

   // sequencer controls
   logic req_acc, load_acc, job_acc;
   logic scan_rd, rate_rd, do_mult, do_write, out_free;

   // datapath values
   logic [TW-1:0]   ft_val;
   logic [TW:0]     sum;
   logic [TW-1:0]   finish;
   logic [IW-1:0]   last_scan;
   int              n_act;

   assign out_free = ~rsp_valid_ff | rsp_ready;
   assign req_ready = (state_ff == efsa_pkg::ST_IDLE);
   assign req_acc   = req_valid & req_ready;
   assign load_acc  = req_acc & (req_cmd == efsa_pkg::CMD_LOAD);
   assign job_acc   = req_acc & (req_cmd == efsa_pkg::CMD_JOB);

   // active server count, zero treated as one, clamped to the file depth
   always_comb begin
      n_act = int'(cfg.server_count);
      if (n_act == 0) begin
         n_act = 1;
      end
      if (n_act > efsa_pkg::NUM_SERVERS) begin
         n_act = efsa_pkg::NUM_SERVERS;
      end
      last_scan = IW'(n_act - 1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         efsa_pkg::ST_IDLE: begin
            if (job_acc) begin
               state_in = efsa_pkg::ST_SCAN;
            end
         end
         efsa_pkg::ST_SCAN: begin
            if (scan_idx_ff == last_ff) begin
               state_in = efsa_pkg::ST_DRAIN;
            end
         end
         efsa_pkg::ST_DRAIN: state_in = efsa_pkg::ST_RATE;
         efsa_pkg::ST_RATE:  state_in = efsa_pkg::ST_MULT;
         efsa_pkg::ST_MULT:  state_in = efsa_pkg::ST_WRITE;
         efsa_pkg::ST_WRITE: begin
            if (out_free) begin
               state_in = efsa_pkg::ST_IDLE;
            end
         end
         default: state_in = efsa_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      scan_rd  = 1'b0;
      rate_rd  = 1'b0;
      do_mult  = 1'b0;
      do_write = 1'b0;
      unique case (state_ff)
         efsa_pkg::ST_IDLE:  ;
         efsa_pkg::ST_SCAN:  scan_rd  = 1'b1;
         efsa_pkg::ST_DRAIN: ;
         efsa_pkg::ST_RATE:  rate_rd  = 1'b1;
         efsa_pkg::ST_MULT:  do_mult  = 1'b1;
         efsa_pkg::ST_WRITE: do_write = out_free;
         default: ;
      endcase
   end

   // never-written free times read as zero
   assign ft_val = ft_vld_ff[rd_tag_ff] ? ft_q_ff : '0;

   // saturating multiply-add result
   assign sum    = {1'b0, best_val_ff} + (TW+1)'(prod_ff);
   assign finish = sum[TW] ? efsa_pkg::TIME_MAX : sum[TW-1:0];

   // datapath next values
   always_comb begin
      scan_idx_in  = scan_idx_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      rd_vld_in    = scan_rd;
      rd_tag_in    = scan_idx_ff;
      best_idx_in  = best_idx_ff;
      best_val_in  = best_val_ff;
      prod_in      = prod_ff;
      max_in       = max_ff;
      ft_vld_in    = ft_vld_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_srv_in   = rsp_srv_ff;
      rsp_fin_in   = rsp_fin_ff;
      rsp_max_in   = rsp_max_ff;

      if (job_acc) begin
         scan_idx_in = '0;
         last_in     = last_scan;
         count_in    = req_item_count;
      end
      if (scan_rd && scan_idx_ff != last_ff) begin
         scan_idx_in = scan_idx_ff + IW'(1);
      end
      // serial compare, lowest index wins a tie
      if (rd_vld_ff) begin
         if (rd_tag_ff == '0 || ft_val < best_val_ff) begin
            best_idx_in = rd_tag_ff;
            best_val_in = ft_val;
         end
      end
      if (do_mult) begin
         prod_in = rate_q_ff * count_ff;
      end
      if (do_write) begin
         ft_vld_in[best_idx_ff] = 1'b1;
         max_in       = (finish > max_ff) ? finish : max_ff;
         rsp_valid_in = 1'b1;
         rsp_srv_in   = efsa_pkg::INDEX_W'(best_idx_ff);
         rsp_fin_in   = finish;
         rsp_max_in   = (finish > max_ff) ? finish : max_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= efsa_pkg::ST_IDLE;
         rd_vld_ff    <= 1'b0;
         ft_vld_ff    <= '0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         ft_vld_ff    <= ft_vld_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      last_ff     <= last_in;
      count_ff    <= count_in;
      rd_tag_ff   <= rd_tag_in;
      best_idx_ff <= best_idx_in;
      best_val_ff <= best_val_in;
      prod_ff     <= prod_in;
      rsp_srv_ff  <= rsp_srv_in;
      rsp_fin_ff  <= rsp_fin_in;
      rsp_max_ff  <= rsp_max_in;
   end

   // rate memory: written by load requests, read at the chosen server
   always_ff @(posedge clock) begin
      if (load_acc && (int'(req_server_index) < efsa_pkg::NUM_SERVERS)) begin
         rate_mem[IW'(req_server_index)] <= req_rate_value;
      end
      if (rate_rd) begin
         rate_q_ff <= rate_mem[best_idx_ff];
      end
   end

   // free-time memory: read during the scan, written back at the end
   always_ff @(posedge clock) begin
      if (do_write) begin
         ft_mem[best_idx_ff] <= finish;
      end
      if (scan_rd) begin
         ft_q_ff <= ft_mem[scan_idx_ff];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chosen_server = rsp_srv_ff;
   assign rsp_finish_time   = rsp_fin_ff;
   assign rsp_makespan      = rsp_max_ff;

endmodule

[src/earliest_free_server_assigner.sv]
// Top level of the earliest-free server assigner.
// Instantiates efsa_csr and efsa_core; depends on efsa_pkg.
//
// Usage:
//   Requests arrive on req_* (valid/ready). cmd LOAD writes the rate of
//   server_index and gives no response. cmd JOB picks
//   the server with the earliest free time among the first N servers
//   (N is server_count, zero read as one, clamped to sixteen; lowest index
//   on a tie), adds rate * item_count to its free time with saturation and
//   returns chosen server, finish time and the running makespan on rsp_*.
//   After a job is accepted, one free-time memory read per cycle feeds a
//   single serial comparator, then come a drain step, rate read, one 8x8
//   multiply and one saturating add with write-back, after which rsp_valid
//   rises. req_ready is high only while idle, so the block takes no new
//   request until a job has finished its write-back.
//   The response sits in an output register; a stalled receiver holds it,
//   and the next job waits in its write-back step until the slot frees.
//   Reset (synchronous) sets server_count to 1, clears all free times and
//   the makespan; server rates are undefined until loaded.
//   server_count lives at byte address 0 of the csr_ port.
module earliest_free_server_assigner (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [efsa_pkg::CMD_W-1:0]        req_cmd,
   input  logic [efsa_pkg::INDEX_W-1:0]      req_server_index,
   input  logic [efsa_pkg::RATE_W-1:0]       req_rate_value,
   input  logic [efsa_pkg::COUNT_W-1:0]      req_item_count,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [efsa_pkg::INDEX_W-1:0]      rsp_chosen_server,
   output logic [efsa_pkg::TIME_W-1:0]       rsp_finish_time,
   output logic [efsa_pkg::TIME_W-1:0]       rsp_makespan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [efsa_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [efsa_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [efsa_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   efsa_pkg::cfg_type cfg;

   // configuration registers
   efsa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // scheduler sequencer and datapath
   efsa_core u_core (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_server_index  (req_server_index),
      .req_rate_value    (req_rate_value),
      .req_item_count    (req_item_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_chosen_server (rsp_chosen_server),
      .rsp_finish_time   (rsp_finish_time),
      .rsp_makespan      (rsp_makespan)
   );

endmodule

[tb/earliest_free_server_assigner_tb.sv]
// Self-checking testbench for earliest_free_server_assigner: directed and random requests
// checked against an in-bench scheduler model, plus a run of heavy jobs on one server.
// Depends on efsa_pkg and the RTL under src/.
module earliest_free_server_assigner_tb;

   localparam int QUIET_LIMIT  = 4000;  // cycles with no handshake before giving up
   localparam int DRAIN_CYCLES = 40;    // idle cycles after the last response is taken
   localparam int MAX_REPORTS  = 60;    // cap on printed mismatches

   typedef struct packed {
      logic [efsa_pkg::INDEX_W-1:0] server;
      logic [efsa_pkg::TIME_W-1:0]  finish;
      logic [efsa_pkg::TIME_W-1:0]  makespan;
   } assignment_type;

   // DUT signals
   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [efsa_pkg::CMD_W-1:0]      req_cmd = efsa_pkg::CMD_LOAD;
   logic [efsa_pkg::INDEX_W-1:0]    req_server_index = '0;
   logic [efsa_pkg::RATE_W-1:0]     req_rate_value = '0;
   logic [efsa_pkg::COUNT_W-1:0]    req_item_count = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [efsa_pkg::INDEX_W-1:0]    rsp_chosen_server;
   logic [efsa_pkg::TIME_W-1:0]     rsp_finish_time;
   logic [efsa_pkg::TIME_W-1:0]     rsp_makespan;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [efsa_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [efsa_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [efsa_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   // scheduler model state
   logic [efsa_pkg::RATE_W-1:0]     rate_table [efsa_pkg::NUM_SERVERS];
   logic [efsa_pkg::TIME_W-1:0]     free_table [efsa_pkg::NUM_SERVERS];
   logic [efsa_pkg::TIME_W-1:0]     peak_finish;
   logic [efsa_pkg::SCOUNT_W-1:0]   server_count_reg;
   assignment_type                  expected_assignments [$];

   // run control and bookkeeping
   bit          gaps_on = 1'b1;
   bit          stall_on = 1'b1;
   int          burst_left = 0;
   int          error_count = 0;
   int          jobs_checked = 0;
   int          loads_sent = 0;
   int          count_writes = 0;
   int          quiet_cycles = 0;
   logic [15:0] ready_pattern = '1;
   logic [3:0]  pattern_pos = '0;

   earliest_free_server_assigner uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_server_index  (req_server_index),
      .req_rate_value    (req_rate_value),
      .req_item_count    (req_item_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_chosen_server (rsp_chosen_server),
      .rsp_finish_time   (rsp_finish_time),
      .rsp_makespan      (rsp_makespan),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------- model

   function automatic void record_rate_load(input logic [efsa_pkg::INDEX_W-1:0] idx,
                                            input logic [efsa_pkg::RATE_W-1:0] rate);
      if (int'(idx) < efsa_pkg::NUM_SERVERS)
         rate_table[idx] = rate;
   endfunction

   // pick the earliest free server, lowest index on a tie, and book the job on it
   function automatic assignment_type predict_assignment(
         input logic [efsa_pkg::COUNT_W-1:0] count);
      int                          scan_width;
      int                          best;
      logic [efsa_pkg::PROD_W-1:0] work;
      logic [efsa_pkg::TIME_W:0]   total;
      assignment_type              result;
      if (server_count_reg == 0)
         scan_width = 1;
      else if (int'(server_count_reg) > efsa_pkg::NUM_SERVERS)
         scan_width = efsa_pkg::NUM_SERVERS;
      else
         scan_width = int'(server_count_reg);
      best = 0;
      for (int i = 1; i < scan_width; i++)
         if (free_table[i] < free_table[best])
            best = i;
      work  = rate_table[best] * count;
      total = {1'b0, free_table[best]} + (efsa_pkg::TIME_W+1)'(work);
      free_table[best] = total[efsa_pkg::TIME_W] ? efsa_pkg::TIME_MAX
                                                 : total[efsa_pkg::TIME_W-1:0];
      if (free_table[best] > peak_finish)
         peak_finish = free_table[best];
      result.server   = best[efsa_pkg::INDEX_W-1:0];
      result.finish   = free_table[best];
      result.makespan = peak_finish;
      return result;
   endfunction

   function automatic void check_field(input string field,
                                       input logic [efsa_pkg::TIME_W-1:0] want,
                                       input logic [efsa_pkg::TIME_W-1:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      end
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin : check_results
      assignment_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_assignments.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: response with none expected, expected nothing actual server %0d",
                        $time, rsp_chosen_server);
         end else begin
            want = expected_assignments.pop_front();
            check_field("chosen_server", efsa_pkg::TIME_W'(want.server),
                        efsa_pkg::TIME_W'(rsp_chosen_server));
            check_field("finish_time", want.finish, rsp_finish_time);
            check_field("makespan", want.makespan, rsp_makespan);
            jobs_checked++;
         end
      end
   end

   // watchdog on handshake progress
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_psel && csr_penable))
         quiet_cycles = 0;
      else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: watchdog, no handshake for %0d cycles", $time, quiet_cycles);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // receiver back-pressure when stall_on: a fresh 16-bit ready pattern at each wrap
   always @(negedge clock) begin
      if (!stall_on) begin
         rsp_ready <= 1'b1;
      end else begin
         if (pattern_pos == 0) begin
            case ($urandom_range(0, 3))
               0: ready_pattern = '1;
               1: ready_pattern = 16'($urandom);
               2: ready_pattern = 16'($urandom & $urandom);
               default: ready_pattern = 16'($urandom | $urandom);
            endcase
            ready_pattern[$urandom_range(0, 15)] = 1'b1;
         end
         rsp_ready <= ready_pattern[pattern_pos];
         pattern_pos = pattern_pos + 1'b1;
      end
   end

   // ---------------------------------------------------------------- drivers

   // send one request; the sender runs in bursts with random gaps while gaps_on is set
   task automatic send_request(input logic [efsa_pkg::CMD_W-1:0] cmd,
                               input logic [efsa_pkg::INDEX_W-1:0] idx,
                               input logic [efsa_pkg::RATE_W-1:0] rate,
                               input logic [efsa_pkg::COUNT_W-1:0] count);
      int gap;
      if (gaps_on && burst_left == 0) begin
         gap = $urandom_range(1, 12);
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_server_index <= idx;
      req_rate_value   <= rate;
      req_item_count   <= count;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (cmd == efsa_pkg::CMD_JOB) begin
         expected_assignments.push_back(predict_assignment(count));
      end else begin
         record_rate_load(idx, rate);
         loads_sent++;
      end
      if (burst_left > 0)
         burst_left--;
   endtask

   task automatic send_job(input logic [efsa_pkg::COUNT_W-1:0] count);
      send_request(efsa_pkg::CMD_JOB, 4'($urandom), 8'($urandom), count);
   endtask

   task automatic send_load(input logic [efsa_pkg::INDEX_W-1:0] idx,
                            input logic [efsa_pkg::RATE_W-1:0] rate);
      send_request(efsa_pkg::CMD_LOAD, idx, rate, 8'($urandom));
   endtask

   task automatic send_random_request();
      if ($urandom_range(0, 99) < 25)
         send_request(efsa_pkg::CMD_LOAD, 4'($urandom_range(0, 15)), pick_byte(),
                      8'($urandom));
      else
         send_request(efsa_pkg::CMD_JOB, 4'($urandom), 8'($urandom), pick_byte());
   endtask

   // hold the sender until every booked job has been answered
   task automatic wait_for_results();
      @(negedge clock) req_valid <= 1'b0;
      while (expected_assignments.size() != 0) @(posedge clock);
   endtask

   task automatic drain_pipeline();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_read(output logic [efsa_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {efsa_pkg::REG_SERVER_COUNT, 2'b00};
      @(negedge clock) csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      data = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // idle the block, write server_count, then read it back
   task automatic write_server_count(input logic [efsa_pkg::SCOUNT_W-1:0] value);
      logic [efsa_pkg::CSR_DATA_W-1:0] word;
      logic [efsa_pkg::CSR_DATA_W-1:0] readback;
      word = '0;
      word[efsa_pkg::SCOUNT_W-1:0] = value;
      drain_pipeline();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {efsa_pkg::REG_SERVER_COUNT, 2'b00};
      csr_pwdata  <= word;
      @(negedge clock) csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      server_count_reg = value;
      count_writes++;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_read(readback);
      check_field("server_count readback", word, readback);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_reset_state();
      logic [efsa_pkg::CSR_DATA_W-1:0] readback;
      csr_read(readback);
      check_field("server_count after reset", efsa_pkg::CSR_DATA_W'(1), readback);
   endtask

   // every server gets a rate before any job can land on it
   task automatic test_load_all_rates();
      logic [efsa_pkg::RATE_W-1:0] rate;
      for (int i = 0; i < efsa_pkg::NUM_SERVERS; i++) begin
         if (i == 0)
            rate = 8'hFF;
         else if (i == 1)
            rate = 8'h00;
         else
            rate = 8'(i * 17);
         send_load(i[efsa_pkg::INDEX_W-1:0], rate);
      end
   endtask

   // ties, zero rate, zero and full counts, and the clamped server counts
   task automatic test_directed_jobs();
      send_job(8'hFF);
      send_job(8'h00);
      write_server_count(5'd16);
      send_job(8'd1);
      send_load(4'd1, 8'd2);
      send_job(8'd200);
      send_job(8'd9);
      write_server_count(5'd0);
      send_job(8'd5);
      write_server_count(5'd31);
      send_job(8'hFF);
      write_server_count(5'd17);
      send_job(8'd128);
   endtask

   task automatic test_random_traffic();
      int phase_counts [8];
      phase_counts = '{16, 1, 0, 31, 17, 8, 2, 16};
      phase_counts[5] = $urandom_range(3, 15);
      phase_counts[6] = $urandom_range(2, 31);
      for (int p = 0; p < 8; p++) begin
         write_server_count(5'(phase_counts[p]));
         gaps_on  = (p % 4 != 0);
         stall_on = gaps_on;
         burst_left = 0;
         for (int k = 0; k < 225; k++) begin
            if (p == 3 && k == 120)
               wait_for_results();
            send_random_request();
         end
      end
   endtask

   // back-to-back full-size jobs on one server, then mixed traffic again
   task automatic test_heavy_jobs();
      write_server_count(5'd1);
      gaps_on  = 1'b0;
      stall_on = 1'b0;
      send_load(4'd0, 8'hFF);
      for (int k = 0; k < 40; k++)
         send_job(8'hFF);
      for (int k = 0; k < 4; k++)
         send_job(pick_byte());
      write_server_count(5'd16);
      gaps_on  = 1'b1;
      stall_on = 1'b1;
      for (int k = 0; k < 40; k++)
         send_random_request();
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      for (int i = 0; i < efsa_pkg::NUM_SERVERS; i++) begin
         rate_table[i] = '0;
         free_table[i] = '0;
      end
      peak_finish      = '0;
      server_count_reg = 5'd1;
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_reset_state();
      test_load_all_rates();
      test_directed_jobs();
      test_random_traffic();
      test_heavy_jobs();
      drain_pipeline();

      $display("Summary: %0d jobs checked, %0d rate loads, %0d server_count writes",
               jobs_checked, loads_sent, count_writes);
      $display("Summary: bursts, receiver stalls and clamped counts; final makespan %0d",
               peak_finish);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

[sim.f]
src/efsa_pkg.sv
src/efsa_csr.sv
src/efsa_core.sv
src/earliest_free_server_assigner.sv
tb/earliest_free_server_assigner_tb.sv
